// ===== hw/rtl/apdh_pkg.sv =====
// Shared types and constants for the atom pair distance histogram.
// Used by apdh_dist and atom_pair_distance_histogram_unit; no dependencies.
package apdh_pkg;

	localparam int unsigned COORD_W = 25;
	localparam int unsigned SUM_W   = 52;
	localparam int unsigned DIST_W  = 26;

	localparam logic [2:0] ST_COUNTED  = 3'd0;
	localparam logic [2:0] ST_BACKBONE = 3'd1;
	localparam logic [2:0] ST_CUTOFF   = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_READ     = 3'd4;

	localparam logic [1:0] REG_CUTOFF    = 2'd0;
	localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
	localparam logic [1:0] REG_BIN_COUNT = 2'd2;

	typedef struct packed {
		logic              done;
		logic [DIST_W-1:0] root;
	} dist_res_t;

	function automatic logic is_backbone(input logic [6:0] t);
		return (t <= 7'd11) || (t >= 7'd22 && t <= 7'd33) ||
		       (t >= 7'd42 && t <= 7'd53) || (t >= 7'd62 && t <= 7'd73);
	endfunction

endpackage

// ===== hw/rtl/apdh_dist.sv =====
// Distance unit: squares the three coordinate deltas one after another and sums them, then takes an
// integer square root one result bit per cycle. Depends on apdh_pkg.
module apdh_dist (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  logic signed [apdh_pkg::COORD_W:0]  dx,
	input  logic signed [apdh_pkg::COORD_W:0]  dy,
	input  logic signed [apdh_pkg::COORD_W:0]  dz,
	output apdh_pkg::dist_res_t                res
);
	localparam int unsigned SW = apdh_pkg::SUM_W;
	localparam int unsigned DW = apdh_pkg::DIST_W;

	logic [25:0] mag_q [3];
	logic [1:0]  sq_cnt_q;
	logic        sq_run_q;
	logic [SW+1:0] rem_q;
	logic [DW-1:0] root_q;
	logic [SW-1:0] sum_q;
	logic [4:0]    it_q;
	logic          rt_run_q;
	logic          done_q;
	logic [51:0]   sq;
	logic [SW+1:0] trial;
	logic [SW+1:0] rem_sh;
	logic [6:0]    sh;

	function automatic logic [25:0] absd(input logic signed [25:0] v);
		logic signed [26:0] e;
		e = {v[25], v};
		return e[26] ? 26'(-e) : 26'(e);
	endfunction

	assign sq = mag_q[sq_cnt_q] * mag_q[sq_cnt_q];
	// bring down two bits of the radicand per iteration
	assign sh = 7'(2 * it_q);
	assign rem_sh = {rem_q[SW-1:0], 2'b00} | (SW+2)'((sum_q >> sh) & 52'd3);
	assign trial = (SW+2)'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_run_q <= 1'b0;
			rt_run_q <= 1'b0;
			done_q   <= 1'b0;
			sq_cnt_q <= '0;
			it_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				sq_run_q <= 1'b1;
				sq_cnt_q <= '0;
			end else if (sq_run_q) begin
				sq_cnt_q <= sq_cnt_q + 2'd1;
				if (sq_cnt_q == 2'd2) begin
					sq_run_q <= 1'b0;
					rt_run_q <= 1'b1;
					it_q     <= 5'd25;
				end
			end else if (rt_run_q) begin
				it_q <= it_q - 5'd1;
				if (it_q == 5'd0) begin
					rt_run_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			mag_q[0] <= absd(dx);
			mag_q[1] <= absd(dy);
			mag_q[2] <= absd(dz);
			sum_q    <= '0;
			rem_q    <= '0;
			root_q   <= '0;
		end else if (sq_run_q) begin
			sum_q <= sum_q + sq;
		end else if (rt_run_q) begin
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[DW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[DW-2:0], 1'b0};
			end
		end
	end

	assign res.done = done_q;
	assign res.root = root_q;

`ifndef SYNTHESIS
	ap_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!(sq_run_q && rt_run_q)) else $error("square and root phases overlap");
	ap_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(rt_run_q)) else $error("done without root phase");
	ap_no_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !sq_run_q && !rt_run_q) else $error("start while busy");
`endif

endmodule

// ===== hw/rtl/atom_pair_distance_histogram_unit.sv =====
// Atom pair distance histogram: one item at a time, one result strobe per item; results
// cannot be stalled, and busy is low again while the strobe is high. A read returns a stored
// counter, a backbone pair is skipped; others pass squaring, root steps (cutoff check),
// division steps (overflow check) and read-modify-write of both counters (one if types equal).
// After reset a clearing pass writes one counter per cycle over all 462400 entries
// (NUM_ATOM_TYPES*NUM_ATOM_TYPES*MAX_BINS); busy stays high meanwhile. Needs apdh_pkg, apdh_dist.
module atom_pair_distance_histogram_unit #(
	parameter int unsigned NUM_ATOM_TYPES = 85,
	parameter int unsigned MAX_BINS       = 64,
	parameter int unsigned COUNTER_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [6:0]  first_type,
	input  logic [6:0]  second_type,
	input  logic        neighbours,
	input  logic signed [24:0] first_x,
	input  logic signed [24:0] first_y,
	input  logic signed [24:0] first_z,
	input  logic signed [24:0] second_x,
	input  logic signed [24:0] second_y,
	input  logic signed [24:0] second_z,
	input  logic [5:0]  read_bin,
	output logic        result_valid,
	output logic [2:0]  status,
	output logic [5:0]  bin_index,
	output logic [31:0] count_value,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int unsigned DEPTH = NUM_ATOM_TYPES * NUM_ATOM_TYPES * MAX_BINS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned BW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int unsigned CW    = COUNTER_WIDTH;
	localparam int unsigned DW    = apdh_pkg::DIST_W;
	localparam logic [CW-1:0] CMAX = '1;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_DIST  = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_RD1   = 9'b000010000,
		S_RD2   = 9'b000100000,
		S_WR1   = 9'b001000000,
		S_WR2   = 9'b010000000,
		S_RDOUT = 9'b100000000
	} state_t;

	state_t state_q;
	logic [15:0] cutoff_q, width_q;
	logic [6:0]  bcount_q;
	logic [AW-1:0] clr_q;
	logic [6:0]  a_q, b_q;
	logic [5:0]  rbin_q;
	logic [DW-1:0] div_rem_q, quo_q;
	logic [4:0]  div_it_q;
	logic [AW-1:0] addr_ab_q, addr_ba_q;
	logic [CW-1:0] cnt_ab_q;
	logic        same_q, rd_ok_q;

	logic [CW-1:0] mem [DEPTH];
	logic [CW-1:0] rdata_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [CW-1:0] wdata;

	apdh_pkg::dist_res_t dres;
	logic go;
	logic acc;
	logic cfg_wr;

	// 25-bit deltas may wrap; recompute with a guard bit
	logic signed [25:0] ddx, ddy, ddz;
	assign ddx = 26'(first_x) - 26'(second_x);
	assign ddy = 26'(first_y) - 26'(second_y);
	assign ddz = 26'(first_z) - 26'(second_z);

	assign pready = 1'b1;
	assign busy   = (state_q != S_IDLE);
	assign acc    = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign go     = acc && !operation &&
	                !(neighbours && apdh_pkg::is_backbone(first_type) &&
	                  apdh_pkg::is_backbone(second_type));

	apdh_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.dx     (ddx),
		.dy     (ddy),
		.dz     (ddz),
		.res    (dres)
	);

	function automatic logic [AW-1:0] addr_of(input logic [6:0] r, input logic [6:0] c,
	                                          input logic [BW-1:0] bn);
		logic [AW+8:0] v;
		v = ((AW+9)'(r) * (AW+9)'(NUM_ATOM_TYPES) + (AW+9)'(c)) * (AW+9)'(MAX_BINS)
		    + (AW+9)'(bn);
		return v[AW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= 16'd20000;
			width_q  <= 16'd320;
			bcount_q <= 7'd63;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				apdh_pkg::REG_CUTOFF:    cutoff_q <= pwdata[15:0];
				apdh_pkg::REG_BIN_WIDTH: width_q  <= pwdata[15:0];
				apdh_pkg::REG_BIN_COUNT: bcount_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			apdh_pkg::REG_CUTOFF:    prdata = {16'd0, cutoff_q};
			apdh_pkg::REG_BIN_WIDTH: prdata = {16'd0, width_q};
			apdh_pkg::REG_BIN_COUNT: prdata = {25'd0, bcount_q};
			default:                 prdata = '0;
		endcase
	end

	logic [DW-1:0] w_ext, div_sh, quo_nx;
	logic [6:0]    lim;
	logic          a_ok, b_ok, bin_ok;
	logic [CW-1:0] inc, upd;
	assign w_ext = (width_q == 16'd0) ? DW'(1) : DW'(width_q);
	assign div_sh = {div_rem_q[DW-2:0], quo_q[DW-1]};
	assign quo_nx = (div_sh >= w_ext) ? {quo_q[DW-2:0], 1'b1} : {quo_q[DW-2:0], 1'b0};
	assign lim = (32'(bcount_q) < MAX_BINS) ? bcount_q : 7'(MAX_BINS);
	assign a_ok = 32'(a_q) < NUM_ATOM_TYPES;
	assign b_ok = 32'(b_q) < NUM_ATOM_TYPES;
	assign bin_ok = quo_nx < DW'(lim);
	assign inc = same_q ? CW'(2) : CW'(1);
	assign upd = (CMAX - rdata_q < inc) ? CMAX : rdata_q + inc;

	always_comb begin
		we = 1'b0; waddr = addr_ab_q; wdata = upd; raddr = addr_ab_q;
		case (state_q)
			S_CLEAR: begin we = 1'b1; waddr = clr_q; wdata = '0; end
			// start the read of a counter in the accepting cycle
			S_IDLE:  raddr = addr_of(first_type, second_type, BW'(read_bin));
			S_RD2:   raddr = addr_ba_q;
			S_WR1:   begin we = 1'b1; waddr = addr_ab_q; end
			S_WR2:   begin we = 1'b1; waddr = addr_ba_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			result_valid <= 1'b0;
			status       <= '0;
			bin_index    <= '0;
			count_value  <= '0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == DEPTH - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (acc) begin
						if (operation) state_q <= S_RDOUT;
						else if (go) state_q <= S_DIST;
						else begin
							result_valid <= 1'b1;
							status       <= apdh_pkg::ST_BACKBONE;
							bin_index    <= '0;
							count_value  <= '0;
						end
					end
				end
				S_RDOUT: begin
					result_valid <= 1'b1;
					status       <= apdh_pkg::ST_READ;
					bin_index    <= rbin_q;
					count_value  <= rd_ok_q ? 32'(rdata_q) : 32'd0;
					state_q      <= S_IDLE;
				end
				S_DIST: begin
					if (dres.done) begin
						if (dres.root >= DW'(cutoff_q)) begin
							result_valid <= 1'b1;
							status       <= apdh_pkg::ST_CUTOFF;
							bin_index    <= '0;
							count_value  <= '0;
							state_q      <= S_IDLE;
						end else state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_it_q == 5'd0) begin
						if (!bin_ok || !a_ok || !b_ok) begin
							result_valid <= 1'b1;
							status       <= apdh_pkg::ST_OVERFLOW;
							bin_index    <= (quo_nx > DW'(63)) ? 6'd63 : quo_nx[5:0];
							count_value  <= '0;
							state_q      <= S_IDLE;
						end else state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_WR1;
				S_WR1: state_q <= same_q ? S_WR2 : S_RD2;
				S_RD2: begin
					state_q <= S_WR2;
				end
				S_WR2: begin
					result_valid <= 1'b1;
					status       <= apdh_pkg::ST_COUNTED;
					bin_index    <= quo_q[5:0];
					count_value  <= 32'(cnt_ab_q);
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			a_q     <= first_type;
			b_q     <= second_type;
			rbin_q  <= read_bin;
			same_q  <= (first_type == second_type);
			rd_ok_q <= (32'(first_type) < NUM_ATOM_TYPES) &&
			           (32'(second_type) < NUM_ATOM_TYPES) && (32'(read_bin) < MAX_BINS);
			addr_ab_q <= addr_of(first_type, second_type, BW'(read_bin));
		end
		if (state_q == S_DIST && dres.done) begin
			div_rem_q <= '0;
			quo_q     <= dres.root;
			div_it_q  <= 5'(DW - 1);
		end
		if (state_q == S_DIV) begin
			// restoring division, one quotient bit per cycle
			if (div_sh >= w_ext) begin
				div_rem_q <= div_sh - w_ext;
				quo_q     <= {quo_q[DW-2:0], 1'b1};
			end else begin
				div_rem_q <= div_sh;
				quo_q     <= {quo_q[DW-2:0], 1'b0};
			end
			if (div_it_q != 5'd0) div_it_q <= div_it_q - 5'd1;
		end
		if (state_q == S_DIV && div_it_q == 5'd0) begin
			addr_ab_q <= addr_of(a_q, b_q, BW'(quo_nx));
			addr_ba_q <= addr_of(b_q, a_q, BW'(quo_nx));
		end
		if (state_q == S_WR1) cnt_ab_q <= upd;
	end

`ifndef SYNTHESIS
	ap_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	ap_busy_res: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy) || $past(start)) else $error("stray result");
	ap_no_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !we) else $error("write while idle");
`endif

endmodule
